// File: rtl/mmtd_pkg.sv
// Package for the multi-mode task dispatcher: sizes, codes, table entry
// and result types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmtd_pkg;

    // Table size and time width
    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // Field widths of the request and response channels
    localparam int OP_W    = 2;
    localparam int DUR_W   = 16;
    localparam int PRI_W   = 3;
    localparam int TIDX_W  = 4;
    localparam int GRANT_W = 16;
    localparam int STAT_W  = 2;

    // Configuration registers
    localparam int MODE_W  = 2;
    localparam int QNT_W   = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_W   = APB_AW - 2;
    localparam logic [REG_W-1:0] REG_MODE    = REG_W'(0);
    localparam logic [REG_W-1:0] REG_QUANTUM = REG_W'(1);
    localparam logic [QNT_W-1:0] QUANTUM_RST = QNT_W'(10);

    // Width for comparing quantum against remaining time
    localparam int CMP_W = (TIME_BITS > QNT_W) ? TIME_BITS : QNT_W;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [IDX_W-1:0]     t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_CLEAR    = 2'd2
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_RR   = 2'd0,
        MODE_PRIO = 2'd1,
        MODE_FIFO = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESP
    } t_state;

    // One table entry
    typedef struct packed {
        logic [PRI_W-1:0] pri;
        t_time            rem;
    } t_entry;

    // One response
    typedef struct packed {
        logic [TIDX_W-1:0]  idx;
        logic [GRANT_W-1:0] granted;
        logic               fin;
        logic               all_fin;
        t_status            status;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/mmtd_ifs.sv
// Valid/ready channel interfaces for the dispatcher requests and responses.
// Depends on mmtd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mmtd_req_if;
    logic                        valid;
    logic                        ready;
    logic [mmtd_pkg::OP_W-1:0]   operation;
    logic [mmtd_pkg::DUR_W-1:0]  task_duration;
    logic [mmtd_pkg::PRI_W-1:0]  task_priority;

    modport source (output valid, operation, task_duration, task_priority, input ready);
    modport sink   (input valid, operation, task_duration, task_priority, output ready);
endinterface

interface mmtd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mmtd_pkg::TIDX_W-1:0]   task_index;
    logic [mmtd_pkg::GRANT_W-1:0]  granted_time;
    logic                          task_finished;
    logic                          all_finished;
    logic [mmtd_pkg::STAT_W-1:0]   result_status;

    modport source (output valid, task_index, granted_time, task_finished,
                    all_finished, result_status, input ready);
    modport sink   (input valid, task_index, granted_time, task_finished,
                    all_finished, result_status, output ready);
endinterface

`default_nettype wire

// File: rtl/multi_mode_task_dispatcher_core.sv
// Multi-mode task dispatcher: top level with task table memory, scan FSM
// and APB register port. Depends on mmtd_pkg and mmtd_ifs.
//
// Use: requests arrive on i_req (load task, dispatch next task, clear
// table); each request yields exactly one response on o_rsp. Mode and
// round-robin quantum are written through the APB port; the user must
// write them only while idle, the block itself does not enforce this.
// Load, clear and unknown operations go from acceptance straight to the
// response state. A dispatch scans the table through a registered-read
// memory, one entry per cycle: round robin and FIFO stop at the first
// unfinished task, priority mode reads all loaded tasks; a dispatch with
// nothing unfinished goes straight to the response state. One request is
// in work at a time; the scan over the single read port of the table sets
// the rate. The response sits in an output register, so the next request
// is taken while a response waits; a finished response holds until the
// receiver takes it, and further requests wait meanwhile.
// Reset empties the table (count and round-robin pointer to zero), sets
// mode to round robin and quantum to 10; table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module multi_mode_task_dispatcher_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    mmtd_req_if.sink                       i_req,
    mmtd_rsp_if.source                     o_rsp,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [mmtd_pkg::APB_AW-1:0]     paddr,
    input  wire [mmtd_pkg::APB_DW-1:0]     pwdata,
    output logic [mmtd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import mmtd_pkg::*;

    // Task table
    t_entry r_mem [MAX_TASKS];
    t_entry r_mem_q;
    logic   w_mem_we;
    t_slot  w_mem_wa;
    t_entry w_mem_wd;

    // Control and scan state
    t_state           r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [QNT_W-1:0]  r_quantum;
    t_cnt    r_task_cnt, n_task_cnt;
    t_cnt    r_open_cnt, n_open_cnt;
    t_slot   r_rr_next,  n_rr_next;
    t_slot   r_rd_addr,  n_rd_addr;
    t_cnt    r_left,     n_left;
    logic    r_q_vld,    n_q_vld;
    logic    r_q_last,   n_q_last;
    t_slot   r_q_slot,   n_q_slot;
    logic    r_best_vld, n_best_vld;
    t_slot   r_sel_slot, n_sel_slot;
    t_entry  r_sel,      n_sel;
    t_result r_res,      n_res;
    t_result r_out,      n_out;
    logic    r_out_vld,  n_out_vld;

    logic        w_req_acc;
    logic        w_wr;
    logic        w_is_prio;
    logic        w_scan_stop;
    t_time       w_dur;
    t_cnt        w_load_open;
    t_slot       w_rr_start;
    logic [CMP_W-1:0] w_qx, w_rx, w_grant;
    t_time       w_new_rem;
    logic        w_fin;
    t_cnt        w_upd_open;

    // Next slot with wrap at the loaded count
    function automatic t_slot f_wrap(input t_slot a, input t_cnt n);
        t_cnt nx;
        nx = CNT_W'(a) + CNT_W'(1);
        return (nx >= n) ? '0 : nx[IDX_W-1:0];
    endfunction

    assign w_req_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_is_prio = (r_mode == MODE_PRIO);
    assign w_dur = TIME_BITS'(i_req.task_duration);
    assign w_load_open = r_open_cnt + CNT_W'(w_dur != '0);
    assign w_rr_start = (CNT_W'(r_rr_next) < r_task_cnt) ? r_rr_next : '0;

    // Stop the scan at the first hit outside priority mode, or after the last entry in priority mode
    assign w_scan_stop = r_q_vld &&
                         ((!w_is_prio && r_mem_q.rem != '0) || (w_is_prio && r_q_last));

    // Grant: min(quantum, remaining) in round robin (a zero quantum counts as one), all remaining otherwise
    assign w_qx = (r_quantum == '0) ? CMP_W'(1) : CMP_W'(r_quantum);
    assign w_rx = CMP_W'(r_sel.rem);
    assign w_grant = (r_mode == MODE_RR && w_qx < w_rx) ? w_qx : w_rx;
    assign w_new_rem = TIME_BITS'(w_rx - w_grant);
    assign w_fin = (w_new_rem == '0);
    assign w_upd_open = r_open_cnt - CNT_W'(w_fin);

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        r_mem_q <= r_mem[r_rd_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    if (i_req.operation == OP_DISPATCH && r_open_cnt != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_stop) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_RESP;
            S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and table access per state
    always_comb begin
        n_task_cnt = r_task_cnt;
        n_open_cnt = r_open_cnt;
        n_rr_next  = r_rr_next;
        n_rd_addr  = r_rd_addr;
        n_left     = r_left;
        n_q_vld    = 1'b0;
        n_q_last   = r_q_last;
        n_q_slot   = r_q_slot;
        n_best_vld = r_best_vld;
        n_sel_slot = r_sel_slot;
        n_sel      = r_sel;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        w_mem_we   = 1'b0;
        w_mem_wa   = r_sel_slot;
        w_mem_wd   = r_sel;

        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    n_res = '{idx: '0, granted: '0, fin: 1'b0,
                              all_fin: (r_open_cnt == '0), status: ST_OK};
                    case (i_req.operation)
                        OP_LOAD: begin
                            if (r_task_cnt == CNT_W'(MAX_TASKS)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                w_mem_we    = 1'b1;
                                w_mem_wa    = r_task_cnt[IDX_W-1:0];
                                w_mem_wd    = '{pri: i_req.task_priority, rem: w_dur};
                                n_task_cnt  = r_task_cnt + CNT_W'(1);
                                n_open_cnt  = w_load_open;
                                n_res.idx   = TIDX_W'(r_task_cnt);
                                n_res.all_fin = (w_load_open == '0);
                            end
                        end
                        OP_DISPATCH: begin
                            if (r_open_cnt == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_rd_addr  = (r_mode == MODE_RR) ? w_rr_start : '0;
                                n_left     = r_task_cnt;
                                n_best_vld = 1'b0;
                            end
                        end
                        OP_CLEAR: begin
                            n_task_cnt    = '0;
                            n_open_cnt    = '0;
                            n_rr_next     = '0;
                            n_res.all_fin = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // Issue the next read
                if (r_left != '0) begin
                    n_q_vld   = 1'b1;
                    n_q_slot  = r_rd_addr;
                    n_q_last  = (r_left == CNT_W'(1));
                    n_rd_addr = f_wrap(r_rd_addr, r_task_cnt);
                    n_left    = r_left - CNT_W'(1);
                end
                // Judge the entry read last cycle
                if (r_q_vld && r_mem_q.rem != '0) begin
                    if (!w_is_prio) begin
                        n_sel_slot = r_q_slot;
                        n_sel      = r_mem_q;
                    end else if (!r_best_vld || r_mem_q.pri < r_sel.pri) begin
                        n_best_vld = 1'b1;
                        n_sel_slot = r_q_slot;
                        n_sel      = r_mem_q;
                    end
                end
            end
            S_UPDATE: begin
                // Write back the reduced remaining time
                w_mem_we   = 1'b1;
                w_mem_wd   = '{pri: r_sel.pri, rem: w_new_rem};
                n_open_cnt = w_upd_open;
                if (r_mode == MODE_RR) begin
                    n_rr_next = f_wrap(r_sel_slot, r_task_cnt);
                end
                n_res = '{idx: TIDX_W'(r_sel_slot), granted: GRANT_W'(w_grant),
                          fin: w_fin, all_fin: (w_upd_open == '0), status: ST_OK};
            end
            S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_task_cnt <= '0;
            r_open_cnt <= '0;
            r_rr_next  <= '0;
            r_left     <= '0;
            r_q_vld    <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_task_cnt <= n_task_cnt;
            r_open_cnt <= n_open_cnt;
            r_rr_next  <= n_rr_next;
            r_left     <= n_left;
            r_q_vld    <= n_q_vld;
            r_best_vld <= n_best_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_q_last   <= n_q_last;
        r_q_slot   <= n_q_slot;
        r_sel_slot <= n_sel_slot;
        r_sel      <= n_sel;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // Response channel
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.task_index    = r_out.idx;
    assign o_rsp.granted_time  = r_out.granted;
    assign o_rsp.task_finished = r_out.fin;
    assign o_rsp.all_finished  = r_out.all_fin;
    assign o_rsp.result_status = r_out.status;

    // APB register port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RR;
            r_quantum <= QUANTUM_RST;
        end else if (w_wr) begin
            unique case (paddr[APB_AW-1:2])
                REG_MODE:    r_mode    <= pwdata[MODE_W-1:0];
                REG_QUANTUM: r_quantum <= pwdata[QNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[APB_AW-1:2])
            REG_MODE:    prdata = APB_DW'(r_mode);
            REG_QUANTUM: prdata = APB_DW'(r_quantum);
            default:     prdata = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_open_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_cnt <= r_task_cnt)
        else $error("unfinished count exceeds task count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_task_cnt <= CNT_W'(MAX_TASKS))
        else $error("task count beyond table size");

    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_open_cnt != '0)
        else $error("scan started with no unfinished task");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc && i_req.operation == OP_CLEAR |=> r_task_cnt == '0 && r_open_cnt == '0)
        else $error("clear left tasks in the table");

    a_update_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPDATE |-> r_sel.rem != '0)
        else $error("dispatch picked a finished task");
`endif

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the multi-mode task dispatcher: drives requests and
// APB register writes, predicts every response and compares them in order.
// Depends on mmtd_pkg, mmtd_ifs and multi_mode_task_dispatcher_core.
`timescale 1ns / 1ps

module tb_top;
    import mmtd_pkg::*;

    // Codes outside the package enums that the block must still handle
    localparam logic [OP_W-1:0]   OP_IGNORED      = 2'd3;
    localparam logic [MODE_W-1:0] MODE_FIFO_ALIAS = 2'd3;

    localparam int SEGMENTS          = 12;
    localparam int ITEMS_PER_SEGMENT = 46;
    localparam int MAX_REPORTS       = 10;

    // Task table predictor and store of expected responses
    class dispatch_scoreboard;
        t_time             remaining [MAX_TASKS];
        logic [PRI_W-1:0]  prio [MAX_TASKS];
        int                loaded;
        int                rr_next;
        logic [MODE_W-1:0] mode;
        logic [QNT_W-1:0]  quantum;
        t_result           expected_results[$];
        int                mismatches;

        function new();
            loaded     = 0;
            rr_next    = 0;
            mode       = MODE_RR;
            quantum    = QUANTUM_RST;
            mismatches = 0;
        endfunction

        function void set_register(logic [REG_W-1:0] index, logic [APB_DW-1:0] value);
            if (index == REG_MODE)
                mode = value[MODE_W-1:0];
            else if (index == REG_QUANTUM)
                quantum = value[QNT_W-1:0];
        endfunction

        function bit all_done();
            for (int i = 0; i < loaded; i++)
                if (remaining[i] != '0) return 1'b0;
            return 1'b1;
        endfunction

        // Slot chosen by the current policy, -1 when nothing is unfinished
        function int pick_slot();
            int start;
            int best;
            int s;
            best = -1;
            if (mode == MODE_RR) begin
                start = (rr_next < loaded) ? rr_next : 0;
                for (int i = 0; i < loaded; i++) begin
                    s = (start + i) % loaded;
                    if (remaining[s] != '0) return s;
                end
                return -1;
            end
            for (int i = 0; i < loaded; i++) begin
                if (remaining[i] == '0) continue;
                if (mode != MODE_PRIO) return i;
                if (best < 0 || prio[i] < prio[best]) best = i;
            end
            return best;
        endfunction

        // Advance the table by one accepted request and queue its response
        function void note_request(logic [OP_W-1:0] op, logic [DUR_W-1:0] dur,
                                   logic [PRI_W-1:0] pri);
            t_result r;
            int slot;
            t_time rem;
            t_time q;
            r = '0;
            r.status = ST_OK;
            if (op == OP_LOAD) begin
                if (loaded >= MAX_TASKS) begin
                    r.status = ST_FULL;
                end else begin
                    r.idx = TIDX_W'(loaded);
                    remaining[loaded] = dur;
                    prio[loaded] = pri;
                    loaded++;
                end
            end else if (op == OP_DISPATCH) begin
                slot = pick_slot();
                if (slot < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    rem = remaining[slot];
                    r.idx = TIDX_W'(slot);
                    if (mode == MODE_RR) begin
                        q = (quantum == '0) ? t_time'(1) : t_time'(quantum);
                        r.granted = (q < rem) ? q : rem;
                        rr_next = (slot + 1) % loaded;
                    end else begin
                        r.granted = rem;
                    end
                    remaining[slot] = rem - r.granted;
                    r.fin = (remaining[slot] == '0);
                end
            end else if (op == OP_CLEAR) begin
                loaded = 0;
                rr_next = 0;
            end
            r.all_fin = all_done();
            expected_results.push_back(r);
        endfunction

        function void report(string what, t_result want, t_result got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t %s: exp idx=%0d grant=%0d fin=%0b all=%0b st=%0d | got idx=%0d grant=%0d fin=%0b all=%0b st=%0d",
                         $realtime, what, want.idx, want.granted, want.fin, want.all_fin,
                         want.status, got.idx, got.granted, got.fin, got.all_fin, got.status);
        endfunction

        // Compare one response with the oldest expectation
        function void check_response(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                report("unexpected response", '0, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.idx !== want.idx || got.granted !== want.granted ||
                got.fin !== want.fin || got.all_fin !== want.all_fin ||
                got.status !== want.status)
                report("response mismatch", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    mmtd_req_if req_ch ();
    mmtd_rsp_if rsp_ch ();

    multi_mode_task_dispatcher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dispatch_scoreboard sb = new();
    int send_idle_pct = 31;
    int recv_idle_pct = 81;

    always #5 i_clk = ~i_clk;

    // Stall the response side at random
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every response taken
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.idx     = rsp_ch.task_index;
            got.granted = rsp_ch.granted_time;
            got.fin     = rsp_ch.task_finished;
            got.all_fin = rsp_ch.all_finished;
            got.status  = t_status'(rsp_ch.result_status);
            sb.check_response(got);
        end
    end

    // Present one request after a random gap and hold it until taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] dur,
                                input logic [PRI_W-1:0] pri);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.task_duration <= dur;
        req_ch.task_priority <= pri;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(op, dur, pri);
    endtask

    // Drop valid and hold off until every response is back
    task automatic drain_responses();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_register(input logic [REG_W-1:0] index, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(index, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly short durations so tasks finish and the table runs dry
    function automatic logic [DUR_W-1:0] random_duration();
        case ($urandom_range(9))
            0: return '0;
            1: return DUR_W'($urandom_range(65500, 65535));
            2: return DUR_W'($urandom_range(0, 65535));
            default: return DUR_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Random part: mostly clear, load a batch, dispatch it down; some noise
    task automatic run_random_items(input int n_items);
        int sent;
        int batch;
        int dispatches;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                send_request(OP_CLEAR, DUR_W'($urandom), PRI_W'($urandom));
                batch = $urandom_range(1, MAX_TASKS + 1);
                for (int i = 0; i < batch; i++)
                    send_request(OP_LOAD, random_duration(), PRI_W'($urandom_range(0, 7)));
                dispatches = batch + $urandom_range(0, 2 * batch + 2);
                for (int i = 0; i < dispatches; i++) begin
                    if ($urandom_range(99) < 15)
                        send_request(OP_LOAD, random_duration(), PRI_W'($urandom_range(0, 7)));
                    else
                        send_request(OP_DISPATCH, DUR_W'($urandom), PRI_W'($urandom));
                end
                sent += 1 + batch + dispatches;
            end else begin
                batch = $urandom_range(1, 6);
                for (int i = 0; i < batch; i++)
                    send_request(OP_W'($urandom_range(0, 3)), random_duration(),
                                 PRI_W'($urandom));
                sent += batch;
            end
        end
    endtask

    initial begin
        logic [MODE_W-1:0] seg_mode;
        int seg_quantum;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_LOAD;
        req_ch.task_duration = '0;
        req_ch.task_priority = '0;
        rsp_ch.ready         = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty dispatch, ignored opcode, field extremes, full table
        send_request(OP_DISPATCH, '0, '0);
        send_request(OP_IGNORED, 16'hFFFF, 3'h7);
        send_request(OP_LOAD, 16'd0, 3'd0);
        send_request(OP_LOAD, 16'hFFFF, 3'd7);
        send_request(OP_LOAD, 16'd25, 3'd2);
        repeat (3) send_request(OP_DISPATCH, 16'hFFFF, 3'h7);
        send_request(OP_CLEAR, 16'hFFFF, 3'h7);
        for (int i = 0; i <= MAX_TASKS; i++)
            send_request(OP_LOAD, (i % 3 == 0) ? 16'd0 : DUR_W'(i * 5), PRI_W'(i));

        // Random segments under several register settings and idle profiles
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                send_idle_pct = 81;
                recv_idle_pct = 31;
            end else if (seg == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg % 6)
                1: seg_mode = MODE_PRIO;
                3: seg_mode = MODE_FIFO;
                5: seg_mode = MODE_FIFO_ALIAS;
                default: seg_mode = MODE_RR;
            endcase
            case (seg)
                0: seg_quantum = 0;
                2: seg_quantum = 1;
                4: seg_quantum = 65535;
                default: seg_quantum = $urandom_range(1, 60);
            endcase
            drain_responses();
            write_register(REG_MODE, APB_DW'(seg_mode));
            write_register(REG_QUANTUM, APB_DW'(seg_quantum));
            run_random_items(ITEMS_PER_SEGMENT);
        end

        drain_responses();
        repeat (30) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: multi_mode_task_dispatcher_core.f
rtl/mmtd_pkg.sv
rtl/mmtd_ifs.sv
rtl/multi_mode_task_dispatcher_core.sv
bench/tb_top.sv
